### rtl/core/hct_pkg.sv
// Shared types and constants for the handheld console timer core.
// No dependencies; imported by hct_step and handheld_console_timer_core.
`default_nettype none

package hct_pkg;

  localparam int unsigned CounterW = 14;
  localparam int unsigned TimerW   = 8;

  localparam logic [CounterW-1:0] COUNTER_RESET = 14'd1;
  localparam logic [TimerW-1:0]   TIMER_MAX     = 8'hFF;

  // Counter bit watched for each rate select code.
  localparam int unsigned BIT_RATE_256 = 7;
  localparam int unsigned BIT_RATE_4   = 1;
  localparam int unsigned BIT_RATE_64  = 5;
  localparam int unsigned BIT_RATE_16  = 3;

  typedef enum logic [1:0] {
    RATE_256 = 2'd0,
    RATE_4   = 2'd1,
    RATE_64  = 2'd2,
    RATE_16  = 2'd3
  } rate_sel_t;

  typedef struct packed {
    logic [CounterW-1:0] tick_counter;
    logic [TimerW-1:0]   timer_count;
    logic                last_edge;
    logic                reload_pending;
  } timer_state_t;

  typedef struct packed {
    logic        div_reset;
    logic [2:0]  timer_control;
    logic [7:0]  timer_modulo;
    logic        timer_write_en;
    logic [7:0]  timer_write_value;
  } tick_item_t;

  typedef struct packed {
    logic [7:0] divider_value;
    logic [7:0] timer_value;
    logic       interrupt_request;
  } tick_result_t;

endpackage

`default_nettype wire

### rtl/core/hct_step.sv
// Combinational next-state logic for one machine tick of the timer.
// Depends on hct_pkg for the state, item and result types.
`default_nettype none

module hct_step import hct_pkg::*; (
  input  timer_state_t state_cur,
  input  tick_item_t   item,
  input  logic         color_mode,
  output timer_state_t state_nxt,
  output tick_result_t result
);

  logic [CounterW-1:0] counter_inc;
  logic [TimerW-1:0]   timer_wr;
  logic [TimerW-1:0]   timer_ld;
  logic [TimerW-1:0]   timer_fin;
  logic                pending_fin;
  logic                irq;
  logic                enable;
  logic                rate_bit;
  logic                edge_sig;
  logic                fall;

  assign enable      = item.timer_control[2];
  assign counter_inc = item.div_reset ? '0 : state_cur.tick_counter + CounterW'(1);
  assign timer_wr    = item.timer_write_en ? item.timer_write_value : state_cur.timer_count;
  assign irq         = state_cur.reload_pending;
  assign timer_ld    = irq ? item.timer_modulo : timer_wr;

  always_comb begin
    unique case (rate_sel_t'(item.timer_control[1:0]))
      RATE_256: rate_bit = counter_inc[BIT_RATE_256];
      RATE_4:   rate_bit = counter_inc[BIT_RATE_4];
      RATE_64:  rate_bit = counter_inc[BIT_RATE_64];
      RATE_16:  rate_bit = counter_inc[BIT_RATE_16];
      default:  rate_bit = 1'b0;
    endcase
  end

  assign edge_sig = color_mode ? rate_bit : (rate_bit & enable);
  assign fall     = state_cur.last_edge & ~edge_sig & (~color_mode | enable);

  always_comb begin
    timer_fin   = timer_ld;
    pending_fin = 1'b0;
    if (fall) begin
      if (timer_ld == TIMER_MAX) begin
        timer_fin   = '0;
        pending_fin = 1'b1;
      end else begin
        timer_fin = timer_ld + TimerW'(1);
      end
    end
  end

  assign state_nxt.tick_counter   = counter_inc;
  assign state_nxt.timer_count    = timer_fin;
  assign state_nxt.last_edge      = edge_sig;
  assign state_nxt.reload_pending = pending_fin;

  assign result.divider_value     = counter_inc[CounterW-1:CounterW-8];
  assign result.timer_value       = timer_fin;
  assign result.interrupt_request = irq;

endmodule

`default_nettype wire

### rtl/core/handheld_console_timer_core.sv
// Top level of the handheld console timer: input register, tick logic, result register.
// Depends on hct_pkg and hct_step.
`default_nettype none

// One tick is accepted every clock while in_stall is low and gives exactly
// one result. A tick is captured in the input register, evaluated against
// the timer state by combinational logic and written to the result register,
// from which its result is offered. in_stall rises only while the input
// register holds a tick and the result register is full and stalled.
// color_mode is written through cfg_wr_en and cfg_wr_data and must be
// changed only while the block is idle.
module handheld_console_timer_core import hct_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic       cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_div_reset,
  input  wire logic [2:0] in_timer_control,
  input  wire logic [7:0] in_timer_modulo,
  input  wire logic       in_timer_write_en,
  input  wire logic [7:0] in_timer_write_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_divider_value,
  output logic [7:0]      out_timer_value,
  output logic            out_interrupt_request
);

  logic         color_mode_r;
  logic         in_v_r;
  tick_item_t   item_r;
  logic         out_v_r;
  tick_result_t result_r;
  timer_state_t state_r;
  timer_state_t state_nxt;
  tick_result_t result_nxt;
  logic         adv;
  logic         fire;

  assign adv      = ~out_v_r | ~out_stall;
  assign fire     = in_v_r & adv;
  assign in_stall = in_v_r & ~adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      color_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (!in_stall) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      item_r.div_reset         <= in_div_reset;
      item_r.timer_control     <= in_timer_control;
      item_r.timer_modulo      <= in_timer_modulo;
      item_r.timer_write_en    <= in_timer_write_en;
      item_r.timer_write_value <= in_timer_write_value;
    end
  end

  hct_step u_step (
    .state_cur  (state_r),
    .item       (item_r),
    .color_mode (color_mode_r),
    .state_nxt  (state_nxt),
    .result     (result_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.tick_counter   <= COUNTER_RESET;
      state_r.timer_count    <= '0;
      state_r.last_edge      <= 1'b0;
      state_r.reload_pending <= 1'b0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid             = out_v_r;
  assign out_divider_value     = result_r.divider_value;
  assign out_timer_value       = result_r.timer_value;
  assign out_interrupt_request = result_r.interrupt_request;

  // A pending reload always shows up as an interrupt on the next result.
  a_irq_follows_pending: assert property (@(posedge clk) disable iff (!rst_n)
    fire && state_r.reload_pending |=> out_interrupt_request)
    else $error("reload pending did not produce an interrupt");

  // No interrupt without a pending reload.
  a_no_spurious_irq: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !state_r.reload_pending |=> !out_interrupt_request)
    else $error("interrupt raised without a pending reload");

  // The result register mirrors the state that the tick left behind.
  a_result_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid && out_divider_value == state_r.tick_counter[CounterW-1:CounterW-8]
             && out_timer_value == state_r.timer_count)
    else $error("result does not match updated state");

  // A divider reset leaves the counter at zero.
  a_div_reset_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item_r.div_reset |=> state_r.tick_counter == '0)
    else $error("divider reset did not clear the counter");

  // A held tick in the input register is not dropped while the output is blocked.
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(state_r))
    else $error("input tick lost or state changed while stalled");

endmodule

`default_nettype wire
